/* src/dominator_set_solver_defines.svh */
// assertion macros for the dominator set solver checker
// expects clk and rst_n in the scope where a macro is used
`ifndef DOMINATOR_SET_SOLVER_DEFINES_SVH
`define DOMINATOR_SET_SOLVER_DEFINES_SVH

// same-cycle implication
`define DSS_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dss check failed");

// next-cycle implication
`define DSS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dss check failed");

`endif

/* src/dss_pkg.sv */
// shared constants, types and helper functions of the dominator set solver
// no dependencies
`default_nettype none

package dss_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int ROW_W        = 32;
    localparam int VIDX_W       = 5;
    localparam int VCNT_W       = 6;
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;

    localparam logic [VCNT_W-1:0] VCOUNT_RST       = VCNT_W'(32);
    localparam logic [VIDX_W-1:0] ENTRY_VERTEX_RST = '0;

    typedef enum logic [0:0] {
        REG_VCOUNT       = 1'b0,
        REG_ENTRY_VERTEX = 1'b1
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_VSEL,
        S_PRED,
        S_OLD,
        S_SCAN,
        S_WB,
        S_EMIT_RD,
        S_EMIT_LD,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic              wr;
        logic              rd;
        logic [VIDX_W-1:0] addr;
        logic [ROW_W-1:0]  wdata;
    } mem_req_t;

    typedef struct packed {
        logic [VCNT_W-1:0] vcount;
        logic [VIDX_W-1:0] entry_vertex;
    } cfg_t;

    function automatic logic [ROW_W-1:0] low_mask(input logic [CNT_W-1:0] n);
        logic [ROW_W-1:0] m;
        if (n >= CNT_W'(ROW_W))
        begin
            m = '1;
        end
        else
        begin
            m = (ROW_W'(1) << n) - ROW_W'(1);
        end
        return m;
    endfunction

    function automatic logic [CNT_W-1:0] active_count(input logic [VCNT_W-1:0] vc);
        logic [CNT_W-1:0] n;
        if (vc > VCNT_W'(MAX_VERTICES))
        begin
            n = CNT_W'(MAX_VERTICES);
        end
        else
        begin
            n = CNT_W'(vc);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

/* src/dss_pred_store.sv */
// predecessor row memory with per-row valid bits, cleared at once
// depends on dss_pkg
`default_nettype none

module dss_pred_store (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire dss_pkg::mem_req_t       req,
    input  wire logic                    clr,
    output logic [dss_pkg::ROW_W-1:0]    rdata
);
    import dss_pkg::*;

    logic [ROW_W-1:0]        mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] valid_reg;
    logic [ROW_W-1:0]        rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clr)
        begin
            valid_reg <= '0;
        end
        else if (req.wr)
        begin
            valid_reg[req.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd)
        begin
            rdata_reg <= valid_reg[req.addr] ? mem[req.addr] : '0;
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* src/dss_dom_store.sv */
// dominator row memory, one read or write port, registered read data
// depends on dss_pkg
`default_nettype none

module dss_dom_store (
    input  wire logic                    clk,
    input  wire dss_pkg::mem_req_t       req,
    output logic [dss_pkg::ROW_W-1:0]    rdata
);
    import dss_pkg::*;

    logic [ROW_W-1:0] mem [MAX_VERTICES];
    logic [ROW_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* src/dss_seq.sv */
// sequencer: row loading, fixed-point sweeps over the dominator memory, result output
// depends on dss_pkg; drives dss_pred_store and dss_dom_store
`default_nettype none

module dss_seq (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire dss_pkg::cfg_t             cfg,
    input  wire logic                      row_valid,
    output logic                           row_ready,
    input  wire logic [dss_pkg::VIDX_W-1:0] vertex_index,
    input  wire logic [dss_pkg::ROW_W-1:0] pred_row,
    input  wire logic                      last_row,
    output logic                           result_valid,
    input  wire logic                      result_ready,
    output logic [dss_pkg::VIDX_W-1:0]     result_vertex,
    output logic [dss_pkg::ROW_W-1:0]      dom_row,
    output logic                           last_result,
    output dss_pkg::mem_req_t              pred_req,
    output logic                           pred_clr,
    input  wire logic [dss_pkg::ROW_W-1:0] pred_rdata,
    output dss_pkg::mem_req_t              dom_req,
    input  wire logic [dss_pkg::ROW_W-1:0] dom_rdata
);
    import dss_pkg::*;

    seq_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  v_reg, v_next;
    logic [CNT_W-1:0]  p_reg, p_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [VIDX_W-1:0] entry_reg, entry_next;
    logic              has_entry_reg, has_entry_next;
    logic [ROW_W-1:0]  preds_reg, preds_next;
    logic [ROW_W-1:0]  old_reg, old_next;
    logic [ROW_W-1:0]  acc_reg, acc_next;
    logic              changed_reg, changed_next;
    logic              result_valid_reg, result_valid_next;
    logic [VIDX_W-1:0] result_vertex_reg, result_vertex_next;
    logic [ROW_W-1:0]  dom_row_reg, dom_row_next;
    logic              last_result_reg, last_result_next;

    logic [ROW_W-1:0]  full;
    logic [ROW_W-1:0]  v_bit;
    logic [ROW_W-1:0]  new_row;
    logic [CNT_W-1:0]  p_inc;
    logic [CNT_W-1:0]  v_inc;
    logic [CNT_W-1:0]  act_n;
    logic              is_entry;
    logic              last_v;
    logic              row_accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            changed_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            changed_reg      <= changed_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg             <= v_next;
        p_reg             <= p_next;
        n_reg             <= n_next;
        entry_reg         <= entry_next;
        has_entry_reg     <= has_entry_next;
        preds_reg         <= preds_next;
        old_reg           <= old_next;
        acc_reg           <= acc_next;
        result_vertex_reg <= result_vertex_next;
        dom_row_reg       <= dom_row_next;
        last_result_reg   <= last_result_next;
    end

    assign full     = low_mask(n_reg);
    assign v_bit    = ROW_W'(1) << v_reg[VIDX_W-1:0];
    assign new_row  = acc_reg | v_bit;
    assign p_inc    = p_reg + CNT_W'(1);
    assign v_inc    = v_reg + CNT_W'(1);
    assign act_n    = active_count(cfg.vcount);
    assign is_entry = has_entry_reg && (v_reg[VIDX_W-1:0] == entry_reg);
    assign last_v   = (v_reg == n_reg - CNT_W'(1));

    assign row_ready  = (state_reg == S_IDLE);
    assign row_accept = row_valid && row_ready;

    always_comb
    begin
        state_next         = state_reg;
        v_next             = v_reg;
        p_next             = p_reg;
        n_next             = n_reg;
        entry_next         = entry_reg;
        has_entry_next     = has_entry_reg;
        preds_next         = preds_reg;
        old_next           = old_reg;
        acc_next           = acc_reg;
        changed_next       = changed_reg;
        result_valid_next  = result_valid_reg;
        result_vertex_next = result_vertex_reg;
        dom_row_next       = dom_row_reg;
        last_result_next   = last_result_reg;
        pred_req           = '0;
        pred_clr           = 1'b0;
        dom_req            = '0;

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (row_accept)
                begin
                    pred_req.wr    = 1'b1;
                    pred_req.addr  = vertex_index;
                    pred_req.wdata = pred_row;
                    if (last_row)
                    begin
                        n_next         = act_n;
                        entry_next     = cfg.entry_vertex;
                        has_entry_next = (CNT_W'(cfg.entry_vertex) < act_n);
                        v_next         = '0;
                        state_next     = (act_n == '0) ? S_DONE : S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                dom_req.wr    = 1'b1;
                dom_req.addr  = v_reg[VIDX_W-1:0];
                dom_req.wdata = is_entry ? v_bit : full;
                if (last_v)
                begin
                    v_next       = '0;
                    changed_next = 1'b0;
                    state_next   = S_VSEL;
                end
                else
                begin
                    v_next = v_inc;
                end
            end
            S_VSEL:
            begin
                if (v_reg == n_reg)
                begin
                    v_next       = '0;
                    changed_next = 1'b0;
                    if (!changed_reg)
                    begin
                        state_next = S_EMIT_RD;
                    end
                end
                else if (is_entry)
                begin
                    v_next = v_inc;
                end
                else
                begin
                    pred_req.rd   = 1'b1;
                    pred_req.addr = v_reg[VIDX_W-1:0];
                    state_next    = S_PRED;
                end
            end
            S_PRED:
            begin
                preds_next   = pred_rdata & full;
                dom_req.rd   = 1'b1;
                dom_req.addr = v_reg[VIDX_W-1:0];
                state_next   = S_OLD;
            end
            S_OLD:
            begin
                old_next     = dom_rdata;
                acc_next     = full;
                p_next       = '0;
                dom_req.rd   = 1'b1;
                dom_req.addr = '0;
                state_next   = S_SCAN;
            end
            S_SCAN:
            begin
                if (preds_reg[p_reg[VIDX_W-1:0]])
                begin
                    acc_next = acc_reg & dom_rdata;
                end
                if (p_reg == n_reg - CNT_W'(1))
                begin
                    state_next = S_WB;
                end
                else
                begin
                    p_next       = p_inc;
                    dom_req.rd   = 1'b1;
                    dom_req.addr = p_inc[VIDX_W-1:0];
                end
            end
            S_WB:
            begin
                dom_req.wr    = 1'b1;
                dom_req.addr  = v_reg[VIDX_W-1:0];
                dom_req.wdata = new_row;
                if (new_row != old_reg)
                begin
                    changed_next = 1'b1;
                end
                v_next     = v_inc;
                state_next = S_VSEL;
            end
            S_EMIT_RD:
            begin
                dom_req.rd   = 1'b1;
                dom_req.addr = v_reg[VIDX_W-1:0];
                state_next   = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next  = 1'b1;
                    result_vertex_next = v_reg[VIDX_W-1:0];
                    dom_row_next       = dom_rdata;
                    last_result_next   = last_v;
                    if (last_v)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        v_next     = v_inc;
                        state_next = S_EMIT_RD;
                    end
                end
            end
            S_DONE:
            begin
                pred_clr   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign result_valid  = result_valid_reg;
    assign result_vertex = result_vertex_reg;
    assign dom_row       = dom_row_reg;
    assign last_result   = last_result_reg;

endmodule

`default_nettype wire

/* src/dominator_set_solver.sv */
// row loading: one word per cycle; the solve starts after the word flagged last_row
// solve: seed the dominator memory, then per pass read, scan and write back the row of each
// non-entry vertex, skipping the entry and closing the pass, until a pass is unchanged
// output: per result word a read (S_EMIT_RD) and a load (S_EMIT_LD) that waits on a stall,
// then the predecessor rows are cleared; one vertex at a time through the single dominator port
// reset: predecessor rows read as zero, vertex count 32, entry_vertex 0, no word pending
`default_nettype none

module dominator_set_solver (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [dss_pkg::APB_AW-1:0]  paddr,
    input  wire logic [dss_pkg::APB_DW-1:0]  pwdata,
    output logic [dss_pkg::APB_DW-1:0]       prdata,
    output logic                             pready,
    input  wire logic                        row_valid,
    output logic                             row_ready,
    input  wire logic [dss_pkg::VIDX_W-1:0]  vertex_index,
    input  wire logic [dss_pkg::ROW_W-1:0]   pred_row,
    input  wire logic                        last_row,
    output logic                             result_valid,
    input  wire logic                        result_ready,
    output logic [dss_pkg::VIDX_W-1:0]       result_vertex,
    output logic [dss_pkg::ROW_W-1:0]        dom_row,
    output logic                             last_result
);
    import dss_pkg::*;

    logic [VCNT_W-1:0] vcount_reg;
    logic [VIDX_W-1:0] entry_vertex_reg;
    reg_idx_t          reg_sel;
    logic              cfg_wr;
    cfg_t              cfg;
    mem_req_t          pred_req;
    mem_req_t          dom_req;
    logic              pred_clr;
    logic [ROW_W-1:0]  pred_rdata;
    logic [ROW_W-1:0]  dom_rdata;

    assign reg_sel = reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg       <= VCOUNT_RST;
            entry_vertex_reg <= ENTRY_VERTEX_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                REG_VCOUNT:
                begin
                    vcount_reg <= pwdata[VCNT_W-1:0];
                end
                REG_ENTRY_VERTEX:
                begin
                    entry_vertex_reg <= pwdata[VIDX_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_VCOUNT:       prdata = APB_DW'(vcount_reg);
            REG_ENTRY_VERTEX: prdata = APB_DW'(entry_vertex_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.vcount       = vcount_reg;
    assign cfg.entry_vertex = entry_vertex_reg;

    dss_pred_store u_pred_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (pred_req),
        .clr   (pred_clr),
        .rdata (pred_rdata)
    );

    dss_dom_store u_dom_store (
        .clk   (clk),
        .req   (dom_req),
        .rdata (dom_rdata)
    );

    dss_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .row_valid     (row_valid),
        .row_ready     (row_ready),
        .vertex_index  (vertex_index),
        .pred_row      (pred_row),
        .last_row      (last_row),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result_vertex (result_vertex),
        .dom_row       (dom_row),
        .last_result   (last_result),
        .pred_req      (pred_req),
        .pred_clr      (pred_clr),
        .pred_rdata    (pred_rdata),
        .dom_req       (dom_req),
        .dom_rdata     (dom_rdata)
    );

endmodule

`default_nettype wire

/* src/dss_checker.sv */
// port-level checks of the dominator set solver, bound to the top level
// depends on dss_pkg and dominator_set_solver_defines.svh
`default_nettype none
`include "dominator_set_solver_defines.svh"

module dss_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [dss_pkg::APB_AW-1:0]  paddr,
    input  wire logic [dss_pkg::APB_DW-1:0]  pwdata,
    input  wire logic [dss_pkg::APB_DW-1:0]  prdata,
    input  wire logic                        pready,
    input  wire logic                        row_valid,
    input  wire logic                        row_ready,
    input  wire logic [dss_pkg::VIDX_W-1:0]  vertex_index,
    input  wire logic [dss_pkg::ROW_W-1:0]   pred_row,
    input  wire logic                        last_row,
    input  wire logic                        result_valid,
    input  wire logic                        result_ready,
    input  wire logic [dss_pkg::VIDX_W-1:0]  result_vertex,
    input  wire logic [dss_pkg::ROW_W-1:0]   dom_row,
    input  wire logic                        last_result
);
    import dss_pkg::*;

    // a stalled result word holds
    `DSS_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
        result_valid && $stable(result_vertex) && $stable(dom_row) && $stable(last_result))

    // an ordinary row keeps the loader open
    `DSS_ASSERT_NEXT(a_row_stays_open, row_valid && row_ready && !last_row, row_ready)

    // the last row starts the solve
    `DSS_ASSERT_NEXT(a_last_row_solves, row_valid && row_ready && last_row, !row_ready)

    // more words follow a word that is not the last
    `DSS_ASSERT_NEXT(a_emit_continues, result_valid && result_ready && !last_result,
        !row_ready)

    // once idle only the final word can still be pending
    `DSS_ASSERT_NOW(a_idle_pending_last, result_valid && row_ready, last_result)

endmodule

bind dominator_set_solver dss_checker u_dss_checker (.*);

`default_nettype wire

/* dv/testbench.sv */
// self-checking testbench for dominator_set_solver: directed graphs, then random graphs
// results are compared with a dominator predictor kept in this file
// depends on dss_pkg and the dominator_set_solver rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dss_pkg::*;

    typedef enum logic [1:0] {
        STEP_ROW,
        STEP_COUNT,
        STEP_ENTRY
    } step_kind_t;

    typedef struct {
        step_kind_t        kind;
        logic [VIDX_W-1:0] vertex;
        logic [ROW_W-1:0]  value;
        logic              last;
        bit                has_check;
        logic [VIDX_W-1:0] check_vertex;
        logic [ROW_W-1:0]  check_dom;
    } step_t;

    typedef struct {
        logic [VIDX_W-1:0] vertex;
        logic [ROW_W-1:0]  dom;
        logic              last;
    } dom_word_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              row_valid;
    logic              row_ready;
    logic [VIDX_W-1:0] vertex_index;
    logic [ROW_W-1:0]  pred_row;
    logic              last_row;
    logic              result_valid;
    logic              result_ready;
    logic [VIDX_W-1:0] result_vertex;
    logic [ROW_W-1:0]  dom_row;
    logic              last_result;

    logic [VCNT_W-1:0] cfg_count = VCNT_W'(32);
    logic [VIDX_W-1:0] cfg_entry = '0;
    logic [ROW_W-1:0]  pred_rows [MAX_VERTICES];
    logic [ROW_W-1:0]  exp_dom [MAX_VERTICES];
    dom_word_t         pending_doms [$];
    step_t             plan [21];

    bit                idle_on = 1'b1;
    int                errors = 0;
    int                rows_sent = 0;
    longint            cycles = 0;
    longint            cycle_limit = 200000;

    dominator_set_solver dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > cycle_limit)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // iterative dominator sets over the stored rows, returns the active vertex count
    function automatic int solve_dominators();
        int               n;
        int               passes;
        logic [ROW_W-1:0] full;
        logic [ROW_W-1:0] preds;
        logic [ROW_W-1:0] acc;
        bit               changed;
        n = (int'(cfg_count) > MAX_VERTICES) ? MAX_VERTICES : int'(cfg_count);
        full = (n >= ROW_W) ? '1 : ((ROW_W'(1) << n) - ROW_W'(1));
        for (int v = 0; v < n; v++)
        begin
            exp_dom[v] = (v == int'(cfg_entry)) ? (ROW_W'(1) << v) : full;
        end
        passes = 0;
        do
        begin
            changed = 1'b0;
            passes++;
            for (int v = 0; v < n; v++)
            begin
                if (v != int'(cfg_entry))
                begin
                    preds = pred_rows[v] & full;
                    acc = full;
                    for (int p = 0; p < n; p++)
                    begin
                        if (preds[p])
                        begin
                            acc &= exp_dom[p];
                        end
                    end
                    acc[v] = 1'b1;
                    if (acc != exp_dom[v])
                    begin
                        changed = 1'b1;
                    end
                    exp_dom[v] = acc;
                end
            end
        end
        while (changed);
        cycle_limit += 4 * (n + passes * (n * (n + 4) + 1) + n * 12 + 50);
        return n;
    endfunction

    task automatic send_row(input logic [VIDX_W-1:0] idx, input logic [ROW_W-1:0] row,
                            input logic last, input bit has_check,
                            input logic [VIDX_W-1:0] check_vertex,
                            input logic [ROW_W-1:0] check_dom);
        int        gap;
        int        n;
        dom_word_t word;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            row_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        row_valid <= 1'b1;
        vertex_index <= idx;
        pred_row <= row;
        last_row <= last;
        do @(posedge clk); while (!row_ready);
        rows_sent++;
        cycle_limit += 20;
        pred_rows[idx] = row;
        if (last)
        begin
            n = solve_dominators();
            for (int k = 0; k < n; k++)
            begin
                word.vertex = VIDX_W'(k);
                word.dom = (has_check && k == int'(check_vertex)) ? check_dom : exp_dom[k];
                word.last = (k == n - 1);
                pending_doms.insert(pending_doms.size(), word);
            end
            foreach (pred_rows[i])
            begin
                pred_rows[i] = '0;
            end
        end
    endtask

    task automatic wait_results();
        row_valid <= 1'b0;
        while (pending_doms.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t r, input logic [APB_DW-1:0] value);
        wait_results();
        repeat (64) @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'({r, 2'b00});
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (r == REG_VCOUNT)
        begin
            cfg_count = value[VCNT_W-1:0];
        end
        else
        begin
            cfg_entry = value[VIDX_W-1:0];
        end
        cycle_limit += 300;
    endtask

    task automatic send_graph();
        int               n;
        int               style;
        int               mode;
        int               j;
        int               t;
        int               order [$];
        logic [ROW_W-1:0] full;
        logic [ROW_W-1:0] row;
        n = (int'(cfg_count) > MAX_VERTICES) ? MAX_VERTICES : int'(cfg_count);
        full = (n >= ROW_W) ? '1 : ((ROW_W'(1) << n) - ROW_W'(1));
        style = $urandom_range(0, 9);
        // noise ahead of the graph, any index
        if (style == 7 || n == 0)
        begin
            repeat ($urandom_range(1, 4))
            begin
                send_row(VIDX_W'($urandom_range(0, 31)), $urandom(), 1'b0, 1'b0, '0, '0);
            end
        end
        if (n == 0 || style == 9)
        begin
            send_row(VIDX_W'($urandom_range(0, 31)), $urandom(), 1'b1, 1'b0, '0, '0);
            return;
        end
        for (int v = 0; v < n; v++)
        begin
            if (style == 8 || $urandom_range(0, 9) < 8)
            begin
                order.insert(order.size(), v);
            end
        end
        if (order.size() == 0)
        begin
            order.insert(0, $urandom_range(0, n - 1));
        end
        for (int i = order.size() - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        // repeated rows overwrite earlier ones
        if (style == 7)
        begin
            order.insert(order.size(), order[$urandom_range(0, order.size() - 1)]);
        end
        foreach (order[i])
        begin
            row = '0;
            if (style == 8)
            begin
                row = (order[i] < n - 1) ? (ROW_W'(1) << (order[i] + 1)) : $urandom() & full;
            end
            else
            begin
                mode = $urandom_range(0, 3);
                case (mode)
                    0:
                    begin
                        repeat ($urandom_range(1, 3)) row[$urandom_range(0, n - 1)] = 1'b1;
                    end
                    1: row = $urandom() & full;
                    2: row = $urandom();
                    default:
                    begin
                        if (order[i] > 0)
                        begin
                            row[$urandom_range(0, order[i] - 1)] = 1'b1;
                        end
                        if ($urandom_range(0, 1))
                        begin
                            row[$urandom_range(0, n - 1)] = 1'b1;
                        end
                    end
                endcase
            end
            send_row(VIDX_W'(order[i]), row, i == order.size() - 1, 1'b0, '0, '0);
        end
    endtask

    task automatic run_phase();
        int pick;
        int count;
        int n;
        int entry;
        pick = $urandom_range(0, 19);
        if (pick < 11)
        begin
            count = $urandom_range(2, 8);
        end
        else if (pick < 15)
        begin
            count = $urandom_range(9, 16);
        end
        else if (pick < 17)
        begin
            count = 32;
        end
        else if (pick == 17)
        begin
            count = 1;
        end
        else if (pick == 18)
        begin
            count = 0;
        end
        else
        begin
            count = $urandom_range(33, 63);
        end
        n = (count > MAX_VERTICES) ? MAX_VERTICES : count;
        if (n == 0 || $urandom_range(0, 3) == 0)
        begin
            entry = $urandom_range(0, 31);
        end
        else
        begin
            entry = $urandom_range(0, n - 1);
        end
        write_reg(REG_VCOUNT, ($urandom() & ~APB_DW'(32'h3F)) | APB_DW'(count));
        write_reg(REG_ENTRY_VERTEX, ($urandom() & ~APB_DW'(32'h1F)) | APB_DW'(entry));
        idle_on = ($urandom_range(0, 3) != 0);
        repeat ($urandom_range(1, 4))
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                wait_results();
            end
            send_graph();
        end
    endtask

    initial
    begin : ready_driver
        int stall;
        result_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 6) : 0;
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!(result_valid && result_ready));
        end
    end

    always @(posedge clk)
    begin : dom_checker
        dom_word_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_doms.size() == 0)
            begin
                $display("%0t: unexpected word, vertex %0d dom %h", $time, result_vertex,
                         dom_row);
                errors++;
            end
            else
            begin
                want = pending_doms.pop_front();
                if (result_vertex !== want.vertex)
                begin
                    $display("%0t: result_vertex expected %0d got %0d", $time, want.vertex,
                             result_vertex);
                    errors++;
                end
                if (dom_row !== want.dom)
                begin
                    $display("%0t: dom_row of vertex %0d expected %h got %h", $time,
                             want.vertex, want.dom, dom_row);
                    errors++;
                end
                if (last_result !== want.last)
                begin
                    $display("%0t: last_result of vertex %0d expected %b got %b", $time,
                             want.vertex, want.last, last_result);
                    errors++;
                end
            end
        end
    end

    initial
    begin : stimulus
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        row_valid = 1'b0;
        vertex_index = '0;
        pred_row = '0;
        last_row = 1'b0;
        foreach (pred_rows[i])
        begin
            pred_rows[i] = '0;
            exp_dom[i] = '0;
        end
        plan = '{
            // reset settings: no edges, then entry with preds, repeats, all-ones row
            '{STEP_ROW,   0,  32'h0000_0000, 1'b1, 1'b1, 31, 32'hFFFF_FFFF},
            '{STEP_ROW,   0,  32'hFFFF_FFFF, 1'b0, 1'b0, 0,  32'h0},
            '{STEP_ROW,   1,  32'h0000_0001, 1'b0, 1'b0, 0,  32'h0},
            '{STEP_ROW,   2,  32'hFFFF_FFFF, 1'b0, 1'b0, 0,  32'h0},
            '{STEP_ROW,   2,  32'h0000_0002, 1'b0, 1'b0, 0,  32'h0},
            '{STEP_ROW,   31, 32'hFFFF_FFFF, 1'b0, 1'b0, 0,  32'h0},
            '{STEP_ROW,   3,  32'h8000_0000, 1'b1, 1'b1, 31, 32'h8000_0001},
            // single vertex, then entry out of range
            '{STEP_COUNT, 0,  32'hFFFF_FFC1, 1'b0, 1'b0, 0,  32'h0},
            '{STEP_ROW,   0,  32'hFFFF_FFFF, 1'b1, 1'b1, 0,  32'h0000_0001},
            '{STEP_ENTRY, 0,  32'h0000_001F, 1'b0, 1'b0, 0,  32'h0},
            '{STEP_ROW,   0,  32'h0000_0001, 1'b1, 1'b1, 0,  32'h0000_0001},
            // count saturates, entry at the top vertex
            '{STEP_COUNT, 0,  32'h0000_003F, 1'b0, 1'b0, 0,  32'h0},
            '{STEP_ROW,   30, 32'h8000_0000, 1'b0, 1'b0, 0,  32'h0},
            '{STEP_ROW,   0,  32'h4000_0000, 1'b1, 1'b1, 31, 32'h8000_0000},
            // count zero gives no words
            '{STEP_COUNT, 0,  32'h0000_0000, 1'b0, 1'b0, 0,  32'h0},
            '{STEP_ROW,   5,  32'h0000_0020, 1'b1, 1'b0, 0,  32'h0},
            '{STEP_COUNT, 0,  32'h0000_0003, 1'b0, 1'b0, 0,  32'h0},
            '{STEP_ENTRY, 0,  32'hFFFF_FFE1, 1'b0, 1'b0, 0,  32'h0},
            '{STEP_ROW,   7,  32'hFFFF_FFFF, 1'b0, 1'b0, 0,  32'h0},
            '{STEP_ROW,   0,  32'h0000_0002, 1'b0, 1'b0, 0,  32'h0},
            '{STEP_ROW,   2,  32'h0000_0001, 1'b1, 1'b1, 2,  32'h0000_0007}
        };
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (plan[i])
        begin
            case (plan[i].kind)
                STEP_ROW: send_row(plan[i].vertex, plan[i].value, plan[i].last,
                                   plan[i].has_check, plan[i].check_vertex, plan[i].check_dom);
                STEP_COUNT: write_reg(REG_VCOUNT, plan[i].value);
                default: write_reg(REG_ENTRY_VERTEX, plan[i].value);
            endcase
        end
        rows_sent = 0;
        while (rows_sent < 360)
        begin
            run_phase();
        end
        wait_results();
        repeat (64) @(posedge clk);
        if (errors == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* dominator_set_solver.f */
+incdir+src
src/dss_pkg.sv
src/dss_pred_store.sv
src/dss_dom_store.sv
src/dss_seq.sv
src/dominator_set_solver.sv
src/dss_checker.sv
dv/testbench.sv
